### rtl/core/tmd_pkg.sv
// Shared constants, angle table and pipeline control type for the motion direction block.
package tmd_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int DATA_WIDTH_DEF    = 16;

    localparam int ANG_TAB_LEN = 24;
    localparam int Z_W         = 28;    // angle accumulator, 2^-24 rad units
    localparam int IN_SHIFT    = 16;    // x, y scaled by 2^16 before rotation
    localparam int GUARD_BITS  = 3;     // negation plus CORDIC gain
    localparam int TURN_SHIFT  = 10;    // Q3.13 half rate to 2^-24 rad
    localparam int FRAC_SHIFT  = 11;    // 2^-24 rad to Q3.13
    localparam int ROUND_HALF  = 1024;
    localparam int HEADING_W   = 16;

    localparam int PI_Q13 = 25736;
    localparam logic signed [Z_W-1:0] PI_Q24 = Z_W'(52707179);

    // atan(2^-i) in 2^-24 rad units
    localparam logic signed [Z_W-1:0] ANG_TAB [ANG_TAB_LEN] = '{
        Z_W'(13176795), Z_W'(7778716), Z_W'(4110060), Z_W'(2086331),
        Z_W'(1047214),  Z_W'(524117),  Z_W'(262123),  Z_W'(131069),
        Z_W'(65536),    Z_W'(32768),   Z_W'(16384),   Z_W'(8192),
        Z_W'(4096),     Z_W'(2048),    Z_W'(1024),    Z_W'(512),
        Z_W'(256),      Z_W'(128),     Z_W'(64),      Z_W'(32),
        Z_W'(16),       Z_W'(8),       Z_W'(4),       Z_W'(2)
    };

    typedef struct packed {
        logic valid;
        logic lin_zero;
    } t_ctl;

endpackage

### rtl/core/tmd_pre.sv
// Input register: scaling, half-plane fold and zero detect ahead of the CORDIC.
module tmd_pre import tmd_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int XW         = DATA_WIDTH + IN_SHIFT + GUARD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_take,
    input  logic signed [DATA_WIDTH-1:0] i_vel_x,
    input  logic signed [DATA_WIDTH-1:0] i_vel_y,
    input  logic signed [DATA_WIDTH-1:0] i_turn_rate,
    output logic signed [XW-1:0]         o_x,
    output logic signed [XW-1:0]         o_y,
    output logic signed [Z_W-1:0]        o_z,
    output logic signed [DATA_WIDTH-1:0] o_w,
    output t_ctl                         o_ctl
);

    logic signed [XW-1:0]  x_ext;
    logic signed [XW-1:0]  y_ext;
    logic signed [XW-1:0]  n_x;
    logic signed [XW-1:0]  n_y;
    logic signed [Z_W-1:0] n_z;
    logic signed [XW-1:0]  r_x;
    logic signed [XW-1:0]  r_y;
    logic signed [Z_W-1:0] r_z;
    logic signed [DATA_WIDTH-1:0] r_w;
    t_ctl                  r_ctl;

    assign x_ext = {{GUARD_BITS{i_vel_x[DATA_WIDTH-1]}}, i_vel_x, {IN_SHIFT{1'b0}}};
    assign y_ext = {{GUARD_BITS{i_vel_y[DATA_WIDTH-1]}}, i_vel_y, {IN_SHIFT{1'b0}}};

    // left half-plane: rotate by pi first
    always_comb begin
        if (i_vel_x[DATA_WIDTH-1]) begin
            n_x = -x_ext;
            n_y = -y_ext;
            n_z = i_vel_y[DATA_WIDTH-1] ? -PI_Q24 : PI_Q24;
        end else begin
            n_x = x_ext;
            n_y = y_ext;
            n_z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl.valid    <= i_take;
            r_ctl.lin_zero <= (i_vel_x == '0) && (i_vel_y == '0);
        end
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
        r_w <= i_turn_rate;
    end

    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;
    assign o_w   = r_w;
    assign o_ctl = r_ctl;

endmodule

### rtl/core/tmd_cordic_stage.sv
// One registered CORDIC vectoring iteration.
module tmd_cordic_stage import tmd_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int XW         = DATA_WIDTH + IN_SHIFT + GUARD_BITS,
    parameter int STAGE      = 0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic signed [XW-1:0]         i_x,
    input  logic signed [XW-1:0]         i_y,
    input  logic signed [Z_W-1:0]        i_z,
    input  logic signed [DATA_WIDTH-1:0] i_w,
    input  t_ctl                         i_ctl,
    output logic signed [XW-1:0]         o_x,
    output logic signed [XW-1:0]         o_y,
    output logic signed [Z_W-1:0]        o_z,
    output logic signed [DATA_WIDTH-1:0] o_w,
    output t_ctl                         o_ctl
);

    logic signed [XW-1:0]  xs;
    logic signed [XW-1:0]  ys;
    logic                  y_pos;
    logic signed [XW-1:0]  r_x;
    logic signed [XW-1:0]  r_y;
    logic signed [Z_W-1:0] r_z;
    logic signed [DATA_WIDTH-1:0] r_w;
    t_ctl                  r_ctl;

    assign xs    = i_x >>> STAGE;
    assign ys    = i_y >>> STAGE;
    assign y_pos = !i_y[XW-1] && (i_y != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
        if (y_pos) begin
            r_x <= i_x + ys;
            r_y <= i_y - xs;
            r_z <= i_z + ANG_TAB[STAGE];
        end else begin
            r_x <= i_x - ys;
            r_y <= i_y + xs;
            r_z <= i_z - ANG_TAB[STAGE];
        end
        r_w <= i_w;
    end

    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;
    assign o_w   = r_w;
    assign o_ctl = r_ctl;

endmodule

### rtl/core/tmd_post.sv
// Two stages: add half turn rate and round to Q3.13, then saturate to +/-pi.
module tmd_post import tmd_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic signed [Z_W-1:0]        i_z,
    input  logic signed [DATA_WIDTH-1:0] i_w,
    input  t_ctl                         i_ctl,
    output logic                         o_valid,
    output logic signed [HEADING_W-1:0]  o_heading
);

    localparam int WT_W = DATA_WIDTH + TURN_SHIFT;
    localparam int S_W  = ((Z_W > WT_W) ? Z_W : WT_W) + 1;
    localparam int Q_W  = S_W - FRAC_SHIFT;
    localparam logic signed [Q_W-1:0] PI_HI = Q_W'(PI_Q13);
    localparam logic signed [Q_W-1:0] PI_LO = -PI_HI;

    logic signed [S_W-1:0] sum;
    logic signed [Q_W-1:0] n_sel;
    logic signed [Q_W-1:0] r_sel;
    logic                  r_valid_a;
    logic signed [Q_W-1:0] n_sat;
    logic signed [HEADING_W-1:0] r_heading;
    logic                  r_valid;

    assign sum = {{(S_W-Z_W){i_z[Z_W-1]}}, i_z}
               + {{(S_W-WT_W){i_w[DATA_WIDTH-1]}}, i_w, {TURN_SHIFT{1'b0}}}
               + S_W'(ROUND_HALF);

    // no linear motion: heading is the turn rate itself
    always_comb begin
        if (i_ctl.lin_zero) begin
            n_sel = {{(Q_W-DATA_WIDTH){i_w[DATA_WIDTH-1]}}, i_w};
        end else begin
            n_sel = sum[S_W-1:FRAC_SHIFT];
        end
    end

    always_comb begin
        priority if (r_sel > PI_HI) begin
            n_sat = PI_HI;
        end else if (r_sel < PI_LO) begin
            n_sat = PI_LO;
        end else begin
            n_sat = r_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_valid_a <= i_ctl.valid;
            r_valid   <= r_valid_a;
        end
        r_sel     <= n_sel;
        r_heading <= n_sat[HEADING_W-1:0];
    end

    assign o_valid   = r_valid;
    assign o_heading = r_heading;

endmodule

### rtl/core/twist_motion_direction_top.sv
// Top level: motion direction from planar velocity, pipelined CORDIC.
//
//  channel   | signals                                  | transfer when
//  ----------+------------------------------------------+--------------------
//  command   | start, busy, i_vel_x, i_vel_y,           | start && !busy
//            | i_turn_rate                              |
//  result    | o_valid, o_heading                       | o_valid (one cycle)
//
//  One command per cycle; busy is always low.
//  The pipeline registers are the input register, one register per
//  CORDIC iteration (stage count capped at 24), round stage, saturate stage.
//  Synchronous active-low reset clears all valid bits; no result is lost
//  since the receiver cannot stall.
module twist_motion_direction_top import tmd_pkg::*; #(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
    parameter int DATA_WIDTH    = DATA_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [DATA_WIDTH-1:0] i_vel_x,
    input  logic signed [DATA_WIDTH-1:0] i_vel_y,
    input  logic signed [DATA_WIDTH-1:0] i_turn_rate,
    output logic                         o_valid,
    output logic signed [HEADING_W-1:0]  o_heading
);

    localparam int NSTG = (CORDIC_STAGES > ANG_TAB_LEN) ? ANG_TAB_LEN : CORDIC_STAGES;
    localparam int XW   = DATA_WIDTH + IN_SHIFT + GUARD_BITS;

    logic signed [XW-1:0]         x_p [NSTG+1];
    logic signed [XW-1:0]         y_p [NSTG+1];
    logic signed [Z_W-1:0]        z_p [NSTG+1];
    logic signed [DATA_WIDTH-1:0] w_p [NSTG+1];
    t_ctl                         ctl_p [NSTG+1];

    assign busy = 1'b0;

    tmd_pre #(
        .DATA_WIDTH (DATA_WIDTH),
        .XW         (XW)
    ) u_pre (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (start && !busy),
        .i_vel_x     (i_vel_x),
        .i_vel_y     (i_vel_y),
        .i_turn_rate (i_turn_rate),
        .o_x         (x_p[0]),
        .o_y         (y_p[0]),
        .o_z         (z_p[0]),
        .o_w         (w_p[0]),
        .o_ctl       (ctl_p[0])
    );

    for (genvar g = 0; g < NSTG; g++) begin : g_stage
        tmd_cordic_stage #(
            .DATA_WIDTH (DATA_WIDTH),
            .XW         (XW),
            .STAGE      (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_x     (x_p[g]),
            .i_y     (y_p[g]),
            .i_z     (z_p[g]),
            .i_w     (w_p[g]),
            .i_ctl   (ctl_p[g]),
            .o_x     (x_p[g+1]),
            .o_y     (y_p[g+1]),
            .o_z     (z_p[g+1]),
            .o_w     (w_p[g+1]),
            .o_ctl   (ctl_p[g+1])
        );
    end

    tmd_post #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_post (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_z       (z_p[NSTG]),
        .i_w       (w_p[NSTG]),
        .i_ctl     (ctl_p[NSTG]),
        .o_valid   (o_valid),
        .o_heading (o_heading)
    );

endmodule

### tb/twist_motion_direction_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for twist_motion_direction_top: directed table, then random commands.
module twist_motion_direction_top_tb import tmd_pkg::*;;

    localparam int STAGES      = CORDIC_STAGES_DEF;
    localparam int DW          = DATA_WIDTH_DEF;
    localparam int LATENCY     = STAGES + 3;
    localparam int N_RANDOM    = 1800;
    localparam int N_CALM_TAIL = 200;
    localparam int N_DIR       = 22;

    localparam longint HEAD_PI  = 25736;        // pi in Q3.13
    localparam longint ANGLE_PI = 52707179;     // pi in 2^-24 rad
    localparam int     ATAN_LEN = 24;

    // atan(2^-i), 2^-24 rad
    localparam longint ATAN_STEP [ATAN_LEN] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2
    };

    typedef struct packed {
        logic signed [DW-1:0]        vx;
        logic signed [DW-1:0]        vy;
        logic signed [DW-1:0]        wz;
        logic                        known;
        logic signed [HEADING_W-1:0] heading;
    } dir_row_t;

    // known = 1: heading typed in; otherwise predicted
    dir_row_t directed_rows [N_DIR] = '{
        '{16'sd0,      16'sd0,      16'sd0,      1'b1, 16'sd0},
        '{16'sd0,      16'sd0,      16'sd32767,  1'b1, 16'sd25736},
        '{16'sd0,      16'sd0,      -16'sd32768, 1'b1, -16'sd25736},
        '{16'sd0,      16'sd0,      16'sd100,    1'b1, 16'sd100},
        '{16'sd0,      16'sd0,      -16'sd25737, 1'b1, -16'sd25736},
        '{16'sd0,      16'sd0,      16'sd25736,  1'b1, 16'sd25736},
        '{-16'sd256,   16'sd0,      16'sd32767,  1'b1, 16'sd25736},
        '{-16'sd256,   16'sd0,      16'sd0,      1'b0, 16'sd0},
        '{16'sd256,    16'sd0,      16'sd0,      1'b0, 16'sd0},
        '{16'sd0,      16'sd256,    16'sd0,      1'b0, 16'sd0},
        '{16'sd0,      -16'sd256,   16'sd0,      1'b0, 16'sd0},
        '{16'sd32767,  16'sd32767,  16'sd0,      1'b0, 16'sd0},
        '{-16'sd32768, -16'sd32768, 16'sd0,      1'b0, 16'sd0},
        '{-16'sd32768, 16'sd32767,  16'sd0,      1'b0, 16'sd0},
        '{16'sd32767,  -16'sd32768, 16'sd0,      1'b0, 16'sd0},
        '{-16'sd32768, -16'sd1,     -16'sd32768, 1'b0, 16'sd0},
        '{-16'sd256,   16'sd0,      -16'sd32768, 1'b0, 16'sd0},
        '{16'sd1,      16'sd1,      16'sd1,      1'b0, 16'sd0},
        '{-16'sd1,     16'sd0,      16'sd1,      1'b0, 16'sd0},
        '{16'sd0,      -16'sd32768, 16'sd32767,  1'b0, 16'sd0},
        '{-16'sd1,     -16'sd1,     -16'sd1,     1'b0, 16'sd0},
        '{16'sd21845,  -16'sd21846, 16'sd21845,  1'b0, 16'sd0}
    };

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic signed [DW-1:0]        i_vel_x = '0;
    logic signed [DW-1:0]        i_vel_y = '0;
    logic signed [DW-1:0]        i_turn_rate = '0;
    logic                        o_valid;
    logic signed [HEADING_W-1:0] o_heading;

    // heading that goes with the command currently on the ports
    logic signed [HEADING_W-1:0] heading_on_port = '0;
    logic signed [HEADING_W-1:0] pending_headings [$];
    int                          heading_errors = 0;

    twist_motion_direction_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_vel_x     (i_vel_x),
        .i_vel_y     (i_vel_y),
        .i_turn_rate (i_turn_rate),
        .o_valid     (o_valid),
        .o_heading   (o_heading)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #1000000;
        $display("tb: failure");
        $finish;
    end

    function automatic longint clamp_pi(input longint v);
        if (v > HEAD_PI) return HEAD_PI;
        if (v < -HEAD_PI) return -HEAD_PI;
        return v;
    endfunction

    // atan2 by vectoring CORDIC in 2^-24 rad, plus half the turn rate, rounded and clamped
    function automatic logic signed [HEADING_W-1:0] predict_heading(
        input logic signed [DW-1:0] vx,
        input logic signed [DW-1:0] vy,
        input logic signed [DW-1:0] wz
    );
        longint x, y, z, xs, ys, h;
        x = longint'(vx) * 65536;
        y = longint'(vy) * 65536;
        z = 0;
        if (vx == 0 && vy == 0) begin
            h = clamp_pi(longint'(wz));
        end else begin
            if (x < 0) begin
                z = (y >= 0) ? ANGLE_PI : -ANGLE_PI;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < STAGES && i < ATAN_LEN; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0) begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ATAN_STEP[i];
                end else begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ATAN_STEP[i];
                end
            end
            h = clamp_pi((z + longint'(wz) * 1024 + 1024) >>> 11);
        end
        return h[HEADING_W-1:0];
    endfunction

    function automatic logic signed [DW-1:0] edge_value();
        case ($urandom_range(0, 6))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return -16'sd1;
            3: return 16'sd1;
            4: return 16'sd25736;
            5: return -16'sd25736;
            default: return 16'sd0;
        endcase
    endfunction

    task automatic send_command(
        input logic signed [DW-1:0]        vx,
        input logic signed [DW-1:0]        vy,
        input logic signed [DW-1:0]        wz,
        input logic                        known,
        input logic signed [HEADING_W-1:0] known_heading
    );
        start           <= 1'b1;
        i_vel_x         <= vx;
        i_vel_y         <= vy;
        i_turn_rate     <= wz;
        heading_on_port <= known ? known_heading : predict_heading(vx, vy, wz);
        do @(posedge i_clk); while (busy);
    endtask

    // start low with junk on the fields
    task automatic hold_off(input int cycles);
        start       <= 1'b0;
        i_vel_x     <= DW'($urandom());
        i_vel_y     <= DW'($urandom());
        i_turn_rate <= DW'($urandom());
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic random_command();
        logic signed [DW-1:0] vx, vy, wz;
        vx = DW'($urandom());
        vy = DW'($urandom());
        wz = DW'($urandom());
        case ($urandom_range(0, 9))
            3: begin
                vx = DW'($urandom_range(0, 8)) - 16'sd4;
                vy = DW'($urandom_range(0, 8)) - 16'sd4;
                wz = DW'($urandom_range(0, 8)) - 16'sd4;
            end
            4: wz = '0;
            5: begin
                vx = '0;
                vy = '0;
            end
            6: begin
                // just off the negative x axis, turn rate pushes past +-pi
                vx = -DW'($urandom_range(1, 32768));
                vy = DW'($urandom_range(0, 64)) - 16'sd32;
                wz = ($urandom_range(0, 1) != 0) ? DW'($urandom_range(0, 32767))
                                                  : -DW'($urandom_range(0, 32768));
            end
            7: begin
                vx = edge_value();
                vy = edge_value();
                wz = edge_value();
            end
            8: vy = '0;
            9: wz = DW'($urandom_range(0, 64)) - 16'sd32;
            default: ;
        endcase
        send_command(vx, vy, wz, 1'b0, '0);
    endtask

    always @(posedge i_clk) begin : result_check
        logic signed [HEADING_W-1:0] want;
        if (i_rst_n && start && !busy)
            pending_headings.push_back(heading_on_port);
        if (i_rst_n && o_valid) begin
            if (pending_headings.size() == 0) begin
                $display("%0t: heading %0d with no command outstanding", $time, o_heading);
                heading_errors++;
            end else begin
                want = pending_headings.pop_front();
                if (o_heading !== want) begin
                    $display("%0t: heading mismatch, expected %0d, got %0d",
                             $time, want, o_heading);
                    heading_errors++;
                end
            end
        end
    end

    initial begin
        bit idle_on;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            if ($urandom_range(0, 3) == 0)
                hold_off($urandom_range(1, 3));
            send_command(directed_rows[k].vx, directed_rows[k].vy, directed_rows[k].wz,
                         directed_rows[k].known, directed_rows[k].heading);
        end

        idle_on = 1'b1;
        for (int k = 0; k < N_RANDOM; k++) begin
            if (k % 64 == 0)
                idle_on = ($urandom_range(0, 2) != 0);
            if (k < N_RANDOM - N_CALM_TAIL && idle_on && $urandom_range(0, 3) == 0)
                hold_off($urandom_range(1, 3));
            random_command();
        end
        start <= 1'b0;

        while (pending_headings.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);

        if (heading_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
